>>> hdl/cset_pkg.sv
// Shared constants, command codes and arithmetic-unit types for the
// call stack exclusive time profiler. No dependencies.
`timescale 1ns / 1ps

package cset_pkg;

   // Table and stack sizes
   localparam int MAX_FUNCS   = 64;
   localparam int STACK_DEPTH = 64;

   // Field widths
   localparam int ID_W   = 6;
   localparam int TIME_W = 32;
   localparam int CNT_W  = 7;
   localparam int AMT_W  = TIME_W + 1;

   // Derived widths
   localparam int TOT_AW = $clog2(MAX_FUNCS);
   localparam int SAW    = $clog2(STACK_DEPTH);
   localparam int LVL_W  = $clog2(STACK_DEPTH + 1);

   // A dump reports at most this many functions
   localparam int ID_LIMIT   = 2 ** ID_W;
   localparam int DUMP_LIMIT = (MAX_FUNCS < ID_LIMIT) ? MAX_FUNCS : ID_LIMIT;

   localparam logic [CNT_W-1:0] COUNT_RESET = CNT_W'(64);

   // Command codes
   localparam logic [1:0] CMD_START = 2'd0;
   localparam logic [1:0] CMD_END   = 2'd1;
   localparam logic [1:0] CMD_DUMP  = 2'd2;

   // Shared arithmetic unit control
   typedef enum logic {
      ALU_ADD_SAT,
      ALU_SUB_CLAMP
   } alu_op_type;

   typedef struct packed {
      alu_op_type op;
      logic       cin;
   } alu_ctl_type;

endpackage

>>> hdl/cset_alu.sv
// Shared add/subtract unit: saturating add or clamped subtract with carry-in.
// Depends on cset_pkg.
`timescale 1ns / 1ps

module cset_alu
   import cset_pkg::*;
(
   input  alu_ctl_type      ctl,
   input  logic [AMT_W-1:0] opa,
   input  logic [AMT_W-1:0] opb,
   output logic [AMT_W-1:0] result
);

   logic [AMT_W:0] opb_x;
   logic [AMT_W:0] sum;

   // One adder: a + b + cin, or a - b + cin
   always_comb begin
      if (ctl.op == ALU_SUB_CLAMP) begin
         opb_x = ~{1'b0, opb};
      end else begin
         opb_x = {1'b0, opb};
      end
      sum = {1'b0, opa} + opb_x + (AMT_W+1)'(ctl.op == ALU_SUB_CLAMP) + (AMT_W+1)'(ctl.cin);
   end

   // Clamp negative differences to zero, saturate sums at the 32-bit maximum
   always_comb begin
      if (ctl.op == ALU_SUB_CLAMP) begin
         result = sum[AMT_W] ? '0 : sum[AMT_W-1:0];
      end else begin
         result = (sum[AMT_W:TIME_W] != '0) ? {1'b0, {TIME_W{1'b1}}} : sum[AMT_W-1:0];
      end
   end

endmodule

>>> hdl/call_stack_exclusive_time_profiler.sv
// Exclusive time profiler: start/end/dump transactions sequenced over one shared adder.
// Start on empty or full stack, end on empty stack, unknown command: busy stays low.
// Other start: busy through S_TOP and S_ACC; end: busy through S_TOP, S_ACC and S_PREV.
// Dump of N results: each result is read in S_DRD and registered out of S_DOUT, one after
// another, busy until the last. Results cannot be stalled; each is shown for one cycle with rsp_strobe.
// Synchronous active-high reset clears level, time, error, totals valid bits, count=64.
`timescale 1ns / 1ps

module call_stack_exclusive_time_profiler
   import cset_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [1:0]          req_command,
   input  logic [ID_W-1:0]     req_function_id,
   input  logic [TIME_W-1:0]   req_timestamp,
   output logic                rsp_strobe,
   output logic [ID_W-1:0]     rsp_result_id,
   output logic [TIME_W-1:0]   rsp_exclusive_total,
   output logic                rsp_error_seen,
   output logic                rsp_last,
   input  logic                csr_we,
   input  logic [CNT_W-1:0]    csr_wdata
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_TOP,
      S_ACC,
      S_PREV,
      S_DRD,
      S_DOUT
   } state_type;

   state_type state_ff, state_in;

   logic [CNT_W-1:0]  count_ff;
   logic [LVL_W-1:0]  level_ff, level_in;
   logic [TIME_W-1:0] prev_ff, prev_in;
   logic              err_ff, err_in;
   logic [MAX_FUNCS-1:0] tv_ff, tv_in;
   logic [CNT_W-1:0]  k_ff, k_in;
   logic [1:0]        cmd_ff, cmd_in;
   logic [ID_W-1:0]   id_ff, id_in;
   logic [TIME_W-1:0] time_ff, time_in;
   logic [AMT_W-1:0]  amount_ff, amount_in;
   logic              strobe_ff, strobe_in;
   logic [ID_W-1:0]   rid_ff, rid_in;
   logic [TIME_W-1:0] rtot_ff, rtot_in;
   logic              rerr_ff, rerr_in;
   logic              rlast_ff, rlast_in;

   // Memories and their registered read data
   logic [ID_W-1:0]   stack_mem [STACK_DEPTH];
   logic [TIME_W-1:0] tot_mem [MAX_FUNCS];
   logic [ID_W-1:0]   stack_rd_ff;
   logic [TIME_W-1:0] tot_rd_ff;
   logic              tv_rd_ff;

   logic              stack_we, stack_re;
   logic [SAW-1:0]    stack_waddr, stack_raddr;
   logic [LVL_W-1:0]  level_m1;
   logic              tot_we, tot_re;
   logic [TOT_AW-1:0] tot_addr;
   logic              charge_ok;
   logic              accept;
   logic [CNT_W-1:0]  eff_count;
   logic [CNT_W-1:0]  k_next;

   alu_ctl_type       alu_ctl;
   logic [AMT_W-1:0]  alu_a, alu_b, alu_res;

   assign accept    = start && (state_ff == S_IDLE);
   assign busy      = (state_ff != S_IDLE);
   assign level_m1  = level_ff - LVL_W'(1);
   assign charge_ok = (32'(stack_rd_ff) < 32'(MAX_FUNCS));
   assign k_next    = k_ff + CNT_W'(1);

   // Clamp the configured count into 1..DUMP_LIMIT
   always_comb begin
      if (count_ff == '0) begin
         eff_count = CNT_W'(1);
      end else if (32'(count_ff) > 32'(DUMP_LIMIT)) begin
         eff_count = CNT_W'(DUMP_LIMIT);
      end else begin
         eff_count = count_ff;
      end
   end

   // Operand selection for the shared unit
   always_comb begin
      alu_ctl = '{op: ALU_ADD_SAT, cin: 1'b0};
      alu_a   = {1'b0, time_ff};
      alu_b   = AMT_W'(1);
      unique case (state_ff)
         S_TOP: begin
            alu_ctl = '{op: ALU_SUB_CLAMP, cin: (cmd_ff == CMD_END)};
            alu_a   = {1'b0, time_ff};
            alu_b   = {1'b0, prev_ff};
         end
         S_ACC: begin
            alu_a = {1'b0, (tv_rd_ff ? tot_rd_ff : '0)};
            alu_b = amount_ff;
         end
         default: begin
         end
      endcase
   end

   cset_alu u_alu (
      .ctl    (alu_ctl),
      .opa    (alu_a),
      .opb    (alu_b),
      .result (alu_res)
   );

   // Sequencer and next-state logic
   always_comb begin
      state_in  = state_ff;
      level_in  = level_ff;
      prev_in   = prev_ff;
      err_in    = err_ff;
      tv_in     = tv_ff;
      k_in      = k_ff;
      cmd_in    = cmd_ff;
      id_in     = id_ff;
      time_in   = time_ff;
      amount_in = amount_ff;
      strobe_in = 1'b0;
      rid_in    = rid_ff;
      rtot_in   = rtot_ff;
      rerr_in   = rerr_ff;
      rlast_in  = rlast_ff;
      stack_we  = 1'b0;
      stack_re  = 1'b0;
      stack_waddr = SAW'(level_ff);
      stack_raddr = SAW'(level_m1);
      tot_we    = 1'b0;
      tot_re    = 1'b0;
      tot_addr  = TOT_AW'(stack_rd_ff);

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd_in  = req_command;
               id_in   = req_function_id;
               time_in = req_timestamp;
               case (req_command)
                  CMD_START: begin
                     if (level_ff == LVL_W'(STACK_DEPTH)) begin
                        err_in = 1'b1;
                     end else if (level_ff == '0) begin
                        stack_we = 1'b1;
                        level_in = level_ff + LVL_W'(1);
                        prev_in  = req_timestamp;
                     end else begin
                        stack_re = 1'b1;
                        state_in = S_TOP;
                     end
                  end
                  CMD_END: begin
                     if (level_ff == '0) begin
                        err_in = 1'b1;
                     end else begin
                        stack_re = 1'b1;
                        state_in = S_TOP;
                     end
                  end
                  CMD_DUMP: begin
                     k_in     = '0;
                     state_in = S_DRD;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_TOP: begin
            // Charge amount, fetch the total of the top function
            amount_in = alu_res;
            tot_re    = 1'b1;
            state_in  = S_ACC;
         end
         S_ACC: begin
            tot_we = charge_ok;
            if (charge_ok) begin
               tv_in[tot_addr] = 1'b1;
            end
            if (cmd_ff == CMD_END) begin
               level_in = level_m1;
               state_in = S_PREV;
            end else begin
               stack_we = 1'b1;
               level_in = level_ff + LVL_W'(1);
               prev_in  = time_ff;
               state_in = S_IDLE;
            end
         end
         S_PREV: begin
            prev_in  = alu_res[TIME_W-1:0];
            state_in = S_IDLE;
         end
         S_DRD: begin
            tot_addr = TOT_AW'(k_ff);
            tot_re   = 1'b1;
            state_in = S_DOUT;
         end
         S_DOUT: begin
            strobe_in = 1'b1;
            rid_in    = ID_W'(k_ff);
            rtot_in   = tv_rd_ff ? tot_rd_ff : '0;
            rerr_in   = err_ff;
            rlast_in  = (k_next == eff_count);
            if (k_next == eff_count) begin
               level_in = '0;
               prev_in  = '0;
               err_in   = 1'b0;
               tv_in    = '0;
               state_in = S_IDLE;
            end else begin
               k_in     = k_next;
               state_in = S_DRD;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Hold state, control and the result strobe
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         count_ff  <= COUNT_RESET;
         level_ff  <= '0;
         prev_ff   <= '0;
         err_ff    <= 1'b0;
         tv_ff     <= '0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         if (csr_we) begin
            count_ff <= csr_wdata;
         end
         level_ff  <= level_in;
         prev_ff   <= prev_in;
         err_ff    <= err_in;
         tv_ff     <= tv_in;
         strobe_ff <= strobe_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      k_ff      <= k_in;
      cmd_ff    <= cmd_in;
      id_ff     <= id_in;
      time_ff   <= time_in;
      amount_ff <= amount_in;
      rid_ff    <= rid_in;
      rtot_ff   <= rtot_in;
      rerr_ff   <= rerr_in;
      rlast_ff  <= rlast_in;
   end

   // Call stack memory
   always_ff @(posedge clock) begin
      if (stack_we) begin
         stack_mem[stack_waddr] <= (state_ff == S_IDLE) ? req_function_id : id_ff;
      end
      if (stack_re) begin
         stack_rd_ff <= stack_mem[stack_raddr];
      end
   end

   // Totals memory with valid bit read alongside
   always_ff @(posedge clock) begin
      if (tot_we) begin
         tot_mem[tot_addr] <= alu_res[TIME_W-1:0];
      end
      if (tot_re) begin
         tot_rd_ff <= tot_mem[tot_addr];
         tv_rd_ff  <= tv_ff[tot_addr];
      end
   end

   assign rsp_strobe          = strobe_ff;
   assign rsp_result_id       = rid_ff;
   assign rsp_exclusive_total = rtot_ff;
   assign rsp_error_seen      = rerr_ff;
   assign rsp_last            = rlast_ff;

`ifndef SYNTH
   a_level_bound: assert property (@(posedge clock) disable iff (reset)
      level_ff <= LVL_W'(STACK_DEPTH))
      else $error("stack level above depth");

   a_strobe_src: assert property (@(posedge clock) disable iff (reset)
      strobe_ff |-> $past(state_ff == S_DOUT))
      else $error("result strobe without dump output step");

   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      (strobe_ff && rlast_ff) |-> (level_ff == '0 && !err_ff && tv_ff == '0))
      else $error("state not cleared after final dump result");

   a_overflow_err: assert property (@(posedge clock) disable iff (reset)
      (accept && req_command == CMD_START && level_ff == LVL_W'(STACK_DEPTH))
      |=> (err_ff && $stable(level_ff)))
      else $error("overflow not flagged");
`endif

endmodule

>>> tb/sv/testbench.sv
// Self-checking bench for the call stack exclusive time profiler: a directed table,
// then random call traces, with each dump report checked against a built-in profile.
// Depends on cset_pkg and the call_stack_exclusive_time_profiler RTL.
`timescale 1ns / 1ps

module testbench
   import cset_pkg::*;
();

   localparam logic [1:0]        CMD_UNUSED    = 2'd3;
   localparam logic [TIME_W-1:0] TIME_MAX      = '1;
   localparam int                SETTLE_CYCLES = 8;
   localparam int                PHASE_EVENTS  = 30;

   typedef struct packed {
      logic [1:0]        cmd;
      logic [ID_W-1:0]   id;
      logic [TIME_W-1:0] ts;
      logic              typed;   // expected report given in the row itself
      logic [TIME_W-1:0] total;
      logic              err;
   } stim_row_type;

   typedef struct packed {
      logic [ID_W-1:0]   id;
      logic [TIME_W-1:0] total;
      logic              err;
      logic              last;
   } total_report_type;

   // Directed rows; typed dumps run with a function count of 1 (one report, id 0)
   localparam stim_row_type DIRECTED [20] = '{
      '{CMD_DUMP,   6'd0,  32'd0,          1'b1, 32'd0,          1'b0},  // dump after reset
      '{CMD_END,    6'd0,  32'd5,          1'b0, 32'd0,          1'b0},  // end on empty stack
      '{CMD_DUMP,   6'd0,  32'd6,          1'b1, 32'd0,          1'b1},  // sticky error shows
      '{CMD_START,  6'd0,  32'd0,          1'b0, 32'd0,          1'b0},
      '{CMD_END,    6'd0,  32'hFFFF_FFFF,  1'b0, 32'd0,          1'b0},  // charge 2^32
      '{CMD_DUMP,   6'd0,  32'd0,          1'b1, 32'hFFFF_FFFF,  1'b0},  // saturated total
      '{CMD_START,  6'd63, 32'd10,         1'b0, 32'd0,          1'b0},
      '{CMD_START,  6'd0,  32'd20,         1'b0, 32'd0,          1'b0},
      '{CMD_START,  6'd0,  32'd15,         1'b0, 32'd0,          1'b0},  // time goes back
      '{CMD_END,    6'd63, 32'd30,         1'b0, 32'd0,          1'b0},  // end id ignored
      '{CMD_END,    6'd21, 32'd40,         1'b0, 32'd0,          1'b0},
      '{CMD_END,    6'd0,  32'd50,         1'b0, 32'd0,          1'b0},
      '{CMD_DUMP,   6'd0,  32'd60,         1'b0, 32'd0,          1'b0},
      '{CMD_UNUSED, 6'd5,  32'd7,          1'b0, 32'd0,          1'b0},  // unknown command
      '{CMD_START,  6'd0,  32'd100,        1'b0, 32'd0,          1'b0},
      '{CMD_START,  6'd42, 32'hFFFF_FFFF,  1'b0, 32'd0,          1'b0},
      '{CMD_END,    6'd0,  32'hFFFF_FFFF,  1'b0, 32'd0,          1'b0},  // time pinned at max
      '{CMD_END,    6'd0,  32'd0,          1'b0, 32'd0,          1'b0},  // negative charge
      '{CMD_DUMP,   6'd0,  32'd0,          1'b0, 32'd0,          1'b0},
      '{CMD_DUMP,   6'd0,  32'd0,          1'b1, 32'd0,          1'b0}   // dump clears all
   };

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              start = 1'b0;
   logic              busy;
   logic [1:0]        req_command = '0;
   logic [ID_W-1:0]   req_function_id = '0;
   logic [TIME_W-1:0] req_timestamp = '0;
   logic              rsp_strobe;
   logic [ID_W-1:0]   rsp_result_id;
   logic [TIME_W-1:0] rsp_exclusive_total;
   logic              rsp_error_seen;
   logic              rsp_last;
   logic              csr_we = 1'b0;
   logic [CNT_W-1:0]  csr_wdata = '0;

   // Profile model state
   logic [ID_W-1:0]   model_stack [STACK_DEPTH];
   int unsigned       model_level = 0;
   logic [TIME_W-1:0] model_prev = '0;
   logic [TIME_W-1:0] model_totals [MAX_FUNCS];
   logic              model_error = 1'b0;
   logic [CNT_W-1:0]  model_count = COUNT_RESET;
   total_report_type  awaited_totals [$];

   int sender_idle_pct = 7;
   int events_sent = 0;
   int mismatch_count = 0;

   call_stack_exclusive_time_profiler dut (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_command         (req_command),
      .req_function_id     (req_function_id),
      .req_timestamp       (req_timestamp),
      .rsp_strobe          (rsp_strobe),
      .rsp_result_id       (rsp_result_id),
      .rsp_exclusive_total (rsp_exclusive_total),
      .rsp_error_seen      (rsp_error_seen),
      .rsp_last            (rsp_last),
      .csr_we              (csr_we),
      .csr_wdata           (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   task automatic flag_mismatch(string what);
      $display("MISMATCH @%0t: %s", $time, what);
      mismatch_count++;
   endtask

   function automatic void clear_profile();
      model_level = 0;
      model_prev  = '0;
      model_error = 1'b0;
      foreach (model_totals[k]) model_totals[k] = '0;
   endfunction

   // Add a charge to one total, saturating at the top of the range
   function automatic void add_time(logic [ID_W-1:0] id, logic [AMT_W-1:0] amount);
      logic [AMT_W:0] sum;
      if (int'(id) < MAX_FUNCS) begin
         sum = {2'b00, model_totals[id]} + {1'b0, amount};
         model_totals[id] = (sum > {2'b00, TIME_MAX}) ? TIME_MAX : sum[TIME_W-1:0];
      end
   endfunction

   // Advance the profile by one accepted transaction; queue dump reports
   function automatic void profile_event(stim_row_type row);
      logic [AMT_W-1:0] amount;
      int n;
      case (row.cmd)
         CMD_START: begin
            if (model_level >= STACK_DEPTH) begin
               model_error = 1'b1;
            end else begin
               if (model_level > 0 && row.ts >= model_prev)
                  add_time(model_stack[model_level-1], AMT_W'(row.ts - model_prev));
               model_stack[model_level] = row.id;
               model_level++;
               model_prev = row.ts;
            end
         end
         CMD_END: begin
            if (model_level == 0) begin
               model_error = 1'b1;
            end else begin
               amount = {1'b0, row.ts} + 1'b1;
               amount = (amount >= {1'b0, model_prev}) ? amount - {1'b0, model_prev} : '0;
               add_time(model_stack[model_level-1], amount);
               model_level--;
               model_prev = (row.ts == TIME_MAX) ? TIME_MAX : row.ts + 1'b1;
            end
         end
         CMD_DUMP: begin
            n = (model_count == 0) ? 1 : int'(model_count);
            if (n > DUMP_LIMIT) n = DUMP_LIMIT;
            if (!row.typed)
               for (int k = 0; k < n; k++)
                  awaited_totals.push_back('{ID_W'(k), model_totals[k], model_error,
                                             k + 1 == n});
            clear_profile();
         end
         default: ;
      endcase
   endfunction

   // Check each report against the oldest one awaited
   always @(posedge clock) begin
      total_report_type want;
      if (!reset && rsp_strobe) begin
         if (awaited_totals.size() == 0) begin
            flag_mismatch($sformatf("unexpected report for function %0d", rsp_result_id));
         end else begin
            want = awaited_totals.pop_front();
            if (rsp_result_id !== want.id)
               flag_mismatch($sformatf("result_id %0d, want %0d", rsp_result_id, want.id));
            if (rsp_exclusive_total !== want.total)
               flag_mismatch($sformatf("function %0d total %0h, want %0h",
                                       want.id, rsp_exclusive_total, want.total));
            if (rsp_error_seen !== want.err)
               flag_mismatch($sformatf("function %0d error_seen %b, want %b",
                                       want.id, rsp_error_seen, want.err));
            if (rsp_last !== want.last)
               flag_mismatch($sformatf("function %0d last %b, want %b",
                                       want.id, rsp_last, want.last));
         end
      end
   end

   // Present one transaction at the falling edge and hold it until accepted
   task automatic send_event(stim_row_type row);
      int gap;
      if ($urandom_range(0, 99) < sender_idle_pct) begin
         gap = $urandom_range(1, 5);
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      start           <= 1'b1;
      req_command     <= row.cmd;
      req_function_id <= row.id;
      req_timestamp   <= row.ts;
      @(posedge clock);
      while (busy) @(posedge clock);
      profile_event(row);
      if (row.typed) awaited_totals.push_back('{ID_W'(0), row.total, row.err, 1'b1});
      if (row.cmd != CMD_UNUSED) events_sent++;
      @(negedge clock);
   endtask

   // Drop start, wait for every awaited report, then let the last event settle
   task automatic wait_idle();
      start <= 1'b0;
      while (awaited_totals.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic set_function_count(logic [CNT_W-1:0] value);
      wait_idle();
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(negedge clock);
      csr_we    <= 1'b0;
      model_count = value;
   endtask

   // One nested call trace with rising time, mostly closed and dumped
   task automatic play_trace(int max_depth, int steps);
      stim_row_type row;
      logic [TIME_W-1:0] t;
      int level;
      int closes;
      int shape;
      row   = '0;
      level = 0;
      t     = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 1000);
      for (int s = 0; s < steps; s++) begin
         if (level == 0 || (level < max_depth && $urandom_range(0, 1) == 1)) begin
            row.cmd = CMD_START;
            row.id  = ($urandom_range(0, 1) == 1) ? ID_W'($urandom_range(0, 7))
                                                   : ID_W'($urandom);
            level++;
         end else begin
            row.cmd = CMD_END;
            row.id  = ID_W'($urandom);
            level--;
         end
         row.ts = t;
         send_event(row);
         t += ($urandom_range(0, 15) == 0) ? $urandom_range(0, 32'h7FFF_FFFF)
                                           : $urandom_range(0, 40);
      end
      // Close the open frames; now and then leave some open or pop one too many
      shape  = $urandom_range(0, 9);
      closes = (shape == 0) ? 0 : (shape == 1) ? level + 1 : level;
      row.cmd = CMD_END;
      for (int c = 0; c < closes; c++) begin
         row.ts = t;
         send_event(row);
         t += $urandom_range(0, 40);
      end
      if ($urandom_range(0, 9) != 0) begin
         row.cmd = CMD_DUMP;
         row.ts  = $urandom;
         send_event(row);
      end
   endtask

   initial begin
      stim_row_type     row;
      logic [CNT_W-1:0] phase_count [5];
      int               phase_idle [5];
      int               phase_start;
      phase_count = '{7'd64, 7'd0, 7'd127, CNT_W'($urandom_range(2, 63)),
                      CNT_W'($urandom_range(2, 63))};
      phase_idle  = '{7, 7, 73, 73, 0};
      clear_profile();

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed table at a function count of 1
      set_function_count(7'd1);
      foreach (DIRECTED[i]) send_event(DIRECTED[i]);

      // Random phases over several counts and idle rates
      for (int p = 0; p < 5; p++) begin
         set_function_count(phase_count[p]);
         sender_idle_pct = phase_idle[p];
         if (p == 0) begin
            // Push past the stack depth to hit overflow, then pop and dump
            row     = '0;
            row.cmd = CMD_START;
            for (int k = 0; k < STACK_DEPTH + 2; k++) begin
               row.id = ID_W'(k);
               row.ts = 32'(k * 3);
               send_event(row);
            end
            row.cmd = CMD_END;
            row.ts  = 32'd500;
            send_event(row);
            row.cmd = CMD_DUMP;
            send_event(row);
         end
         phase_start = events_sent;
         while (events_sent - phase_start < PHASE_EVENTS) begin
            if ($urandom_range(0, 4) == 0) begin
               row       = '0;
               row.cmd   = 2'($urandom);
               row.id    = ID_W'($urandom);
               row.ts    = $urandom;
               send_event(row);
            end else begin
               play_trace($urandom_range(1, 6), $urandom_range(2, 12));
            end
         end
      end

      wait_idle();
      repeat (2 * DUMP_LIMIT + 20) @(negedge clock);
      if (mismatch_count == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

   // Hard stop well beyond the slowest correct run
   initial begin
      #10_000_000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule

>>> files.f
hdl/cset_pkg.sv
hdl/cset_alu.sv
hdl/call_stack_exclusive_time_profiler.sv
tb/sv/testbench.sv
